@@ hw/rtl/ukt_pkg.sv @@
// ----------------------------------------------------------------------------
// ukt_pkg
// Shared types, codes and sizes for the unordered key table.
// ----------------------------------------------------------------------------
package ukt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NOT_FOUND = 3'd1;
  localparam logic [2:0] STS_DUPLICATE = 3'd2;
  localparam logic [2:0] STS_FULL      = 3'd3;
  localparam logic [2:0] STS_EMPTY     = 3'd4;

  typedef logic signed [31:0] word_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef struct packed {
    logic [1:0] command;
    word_t      key;
    word_t      entry_value;
  } ukt_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] position;
    word_t      found_value;
    logic [6:0] fill_count;
  } ukt_out_t;

  typedef struct packed {
    logic  cmp;
    logic  ins;
    logic  rem;
    cnt_t  count;
    idx_t  pos;
    word_t cmp_key;
    word_t wr_key;
    word_t wr_val;
  } ukt_cell_ctl_t;

  typedef enum logic [1:0] {
    UKT_IDLE,
    UKT_ENC,
    UKT_EXEC
  } ukt_state_t;

endpackage

@@ hw/rtl/ukt_cell.sv @@
// ----------------------------------------------------------------------------
// ukt_cell
// One table slot: holds a key/value pair, compares against the request key,
// loads on insert and takes its upper neighbor's pair on remove.
// ----------------------------------------------------------------------------
module ukt_cell (
  input  logic                  clk,
  input  ukt_pkg::idx_t         cell_idx,
  input  ukt_pkg::ukt_cell_ctl_t ctl,
  input  ukt_pkg::word_t        nb_key,
  input  ukt_pkg::word_t        nb_val,
  output ukt_pkg::word_t        key_q,
  output ukt_pkg::word_t        val_q,
  output logic                  match_q
);
  import ukt_pkg::*;

  word_t key_r, key_nxt;
  word_t val_r, val_nxt;
  logic  match_r, match_nxt;
  cnt_t  idx_ext;

  assign idx_ext = cnt_t'(cell_idx);

  always_comb begin
    key_nxt   = key_r;
    val_nxt   = val_r;
    match_nxt = match_r;
    if (ctl.cmp) begin
      match_nxt = (key_r == ctl.cmp_key) && (idx_ext < ctl.count);
    end
    if (ctl.ins && (idx_ext == ctl.count)) begin
      key_nxt = ctl.wr_key;
      val_nxt = ctl.wr_val;
    end else if (ctl.rem && (cell_idx >= ctl.pos) && ((idx_ext + cnt_t'(1)) < ctl.count)) begin
      key_nxt = nb_key;
      val_nxt = nb_val;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    match_r <= match_nxt;
  end

  assign key_q   = key_r;
  assign val_q   = val_r;
  assign match_q = match_r;

endmodule

@@ hw/rtl/ukt_encode.sv @@
// ----------------------------------------------------------------------------
// ukt_encode
// Turns the cells' match flags into hit, index and value; keys are unique
// in the table, so at most one flag is set.
// ----------------------------------------------------------------------------
module ukt_encode (
  input  logic [ukt_pkg::CAPACITY-1:0] match,
  input  ukt_pkg::word_t               cell_val [ukt_pkg::CAPACITY],
  output logic                         hit,
  output ukt_pkg::idx_t                pos,
  output ukt_pkg::word_t               value
);
  import ukt_pkg::*;

  always_comb begin
    pos   = '0;
    value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos   = pos | (match[i] ? idx_t'(i) : idx_t'(0));
      value = value | (match[i] ? cell_val[i] : word_t'(0));
    end
    hit = |match;
  end

endmodule

@@ hw/rtl/unordered_key_table_unit.sv @@
// ----------------------------------------------------------------------------
// unordered_key_table_unit
// Key/value table kept in arrival order in a chain of cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The cells compare
// the key in the cycle of acceptance, the match flags are encoded in the
// next (UKT_ENC), and the table is updated in UKT_EXEC after that (on remove
// each cell from the removed one upward takes its neighbor's pair at once).
// The result shows on out_rsp with out_valid for exactly one cycle after
// that, and the receiver cannot stall it; busy is already low in that cycle,
// so a new request may be started while the result is on the ports. Exactly
// one result comes back for each request.
// ----------------------------------------------------------------------------
module unordered_key_table_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ukt_pkg::ukt_in_t  in_req,
  output logic              out_valid,
  output ukt_pkg::ukt_out_t out_rsp
);
  import ukt_pkg::*;

  ukt_state_t    state_r, state_nxt;
  cnt_t          count_r, count_nxt;
  logic [1:0]    cmd_r;
  word_t         key_r;
  word_t         val_r;
  logic          hit_r;
  idx_t          pos_r;
  word_t         fval_r;
  logic          out_valid_r, out_valid_nxt;
  ukt_out_t      out_r, out_nxt;

  ukt_cell_ctl_t ctl;
  logic          accept;
  logic          enc_hit;
  idx_t          enc_pos;
  word_t         enc_val;
  logic [CAPACITY-1:0] match;
  word_t         cell_key [CAPACITY];
  word_t         cell_val [CAPACITY];

  assign accept = start && (state_r == UKT_IDLE);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t nb_key, nb_val;
    if (g == CAPACITY - 1) begin : g_last
      assign nb_key = '0;
      assign nb_val = '0;
    end else begin : g_mid
      assign nb_key = cell_key[g+1];
      assign nb_val = cell_val[g+1];
    end
    ukt_cell u_cell (
      .clk      (clk),
      .cell_idx (idx_t'(g)),
      .ctl      (ctl),
      .nb_key   (nb_key),
      .nb_val   (nb_val),
      .key_q    (cell_key[g]),
      .val_q    (cell_val[g]),
      .match_q  (match[g])
    );
  end

  ukt_encode u_encode (
    .match    (match),
    .cell_val (cell_val),
    .hit      (enc_hit),
    .pos      (enc_pos),
    .value    (enc_val)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ctl           = '0;
    ctl.cmp       = accept;
    ctl.cmp_key   = in_req.key;
    ctl.count     = count_r;
    ctl.pos       = pos_r;
    ctl.wr_key    = key_r;
    ctl.wr_val    = val_r;
    unique case (state_r)
      UKT_IDLE: begin
        if (accept) begin
          state_nxt = UKT_ENC;
        end
      end
      UKT_ENC: begin
        state_nxt = UKT_EXEC;
      end
      UKT_EXEC: begin
        state_nxt           = UKT_IDLE;
        out_valid_nxt       = 1'b1;
        out_nxt.status      = STS_OK;
        out_nxt.position    = '0;
        out_nxt.found_value = '0;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (count_r >= cnt_t'(CAPACITY)) begin
              out_nxt.status = STS_FULL;
            end else if (hit_r) begin
              out_nxt.status = STS_DUPLICATE;
            end else begin
              ctl.ins          = 1'b1;
              out_nxt.position = 6'(count_r);
              count_nxt        = count_r + cnt_t'(1);
            end
          end
          CMD_REMOVE: begin
            if (count_r == '0) begin
              out_nxt.status = STS_EMPTY;
            end else if (!hit_r) begin
              out_nxt.status = STS_NOT_FOUND;
            end else begin
              ctl.rem             = 1'b1;
              out_nxt.position    = 6'(pos_r);
              out_nxt.found_value = fval_r;
              count_nxt           = count_r - cnt_t'(1);
            end
          end
          default: begin
            if (!hit_r) begin
              out_nxt.status = STS_NOT_FOUND;
            end else begin
              out_nxt.position    = 6'(pos_r);
              out_nxt.found_value = fval_r;
            end
          end
        endcase
        out_nxt.fill_count = 7'(count_nxt);
      end
      default: begin
        state_nxt = UKT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= UKT_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_req.command;
      key_r <= in_req.key;
      val_r <= in_req.entry_value;
    end
    if (state_r == UKT_ENC) begin
      hit_r  <= enc_hit;
      pos_r  <= enc_pos;
      fval_r <= enc_val;
    end
    out_r <= out_nxt;
  end

  assign busy      = (state_r != UKT_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

@@ hw/rtl/ukt_checker.sv @@
// ----------------------------------------------------------------------------
// ukt_checker
// Port-level checks for the unordered key table, bound to the top level.
// ----------------------------------------------------------------------------
module ukt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input ukt_pkg::ukt_out_t out_rsp
);
  import ukt_pkg::*;

  // every accepted request is answered with a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result missing three cycles after request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.fill_count <= 7'(CAPACITY)))
    else $error("fill count above capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status != STS_OK)) |->
      ((out_rsp.position == '0) && (out_rsp.found_value == '0)))
    else $error("failed request reports nonzero position or value");

endmodule

bind unordered_key_table_unit ukt_checker u_ukt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

@@ tb/unordered_key_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unordered_key_table_checker
// Watches the request and result channels of the key table, keeps its own
// copy of the table, predicts one result per accepted request and compares
// each strobed result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module unordered_key_table_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  ukt_pkg::ukt_in_t  in_req,
  input  logic              out_valid,
  input  ukt_pkg::ukt_out_t out_rsp,
  output int                mismatches,
  output int                outstanding,
  output int                checked,
  output int                dup_seen,
  output int                full_seen,
  output int                empty_seen
);
  import ukt_pkg::*;

  word_t    table_keys [CAPACITY];
  word_t    table_vals [CAPACITY];
  int       table_fill;
  ukt_out_t rsp_due [$];
  ukt_out_t want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
    dup_seen    = 0;
    full_seen   = 0;
    empty_seen  = 0;
    table_fill  = 0;
  end

  function automatic ukt_out_t apply_command(ukt_in_t req);
    ukt_out_t rsp;
    int       hit;
    rsp = '0;
    rsp.status = STS_OK;
    hit = -1;
    for (int i = 0; i < table_fill; i++) begin
      if (hit < 0 && table_keys[i] == req.key) hit = i;
    end
    case (req.command)
      CMD_INSERT: begin
        if (table_fill >= CAPACITY) begin
          rsp.status = STS_FULL;
        end else if (hit >= 0) begin
          rsp.status = STS_DUPLICATE;
        end else begin
          table_keys[table_fill] = req.key;
          table_vals[table_fill] = req.entry_value;
          rsp.position = 6'(table_fill);
          table_fill++;
        end
      end
      CMD_REMOVE: begin
        if (table_fill == 0) begin
          rsp.status = STS_EMPTY;
        end else if (hit < 0) begin
          rsp.status = STS_NOT_FOUND;
        end else begin
          rsp.position    = 6'(hit);
          rsp.found_value = table_vals[hit];
          for (int i = hit; i + 1 < table_fill; i++) begin
            table_keys[i] = table_keys[i + 1];
            table_vals[i] = table_vals[i + 1];
          end
          table_fill--;
        end
      end
      // search, and the unused code which behaves as a search
      default: begin
        if (hit < 0) begin
          rsp.status = STS_NOT_FOUND;
        end else begin
          rsp.position    = 6'(hit);
          rsp.found_value = table_vals[hit];
        end
      end
    endcase
    rsp.fill_count = 7'(table_fill);
    return rsp;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      table_fill = 0;
      rsp_due.delete();
    end else begin
      if (out_valid) begin
        checked++;
        if (rsp_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result with no request pending: status %0d pos %0d value %0d fill %0d",
                     $realtime, out_rsp.status, out_rsp.position,
                     $signed(out_rsp.found_value), out_rsp.fill_count);
        end else begin
          want = rsp_due.pop_front();
          if (out_rsp.status !== want.status || out_rsp.position !== want.position ||
              out_rsp.found_value !== want.found_value ||
              out_rsp.fill_count !== want.fill_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d mismatch", $realtime, checked);
              $display("  expected status %0d pos %0d value %0d fill %0d",
                       want.status, want.position, $signed(want.found_value),
                       want.fill_count);
              $display("  actual   status %0d pos %0d value %0d fill %0d",
                       out_rsp.status, out_rsp.position, $signed(out_rsp.found_value),
                       out_rsp.fill_count);
            end
          end
          case (want.status)
            STS_DUPLICATE: dup_seen++;
            STS_FULL:      full_seen++;
            STS_EMPTY:     empty_seen++;
            default: ;
          endcase
        end
      end
      if (start && !busy) rsp_due.push_back(apply_command(in_req));
    end
    outstanding = rsp_due.size();
  end

endmodule

@@ tb/unordered_key_table_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unordered_key_table_unit_test
// Drives search, insert and remove requests into the key table: a short
// directed sequence over the corner cases, then random requests that fill
// and drain the table in turns over a small key pool, with random idle gaps.
// ----------------------------------------------------------------------------
module unordered_key_table_unit_test;
  import ukt_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam word_t      WORD_MIN     = 32'h8000_0000;
  localparam word_t      WORD_MAX     = 32'h7fff_ffff;
  localparam int         RANDOM_ITEMS = 1500;
  localparam int         QUIET_TAIL   = 200;
  localparam int         KEY_POOL     = 96;
  localparam int         BLOCK_LEN    = 120;
  localparam int         CYCLE_LIMIT  = 200000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  ukt_in_t  in_req;
  logic     out_valid;
  ukt_out_t out_rsp;

  int mismatches;
  int outstanding;
  int checked;
  int dup_seen;
  int full_seen;
  int empty_seen;
  int cycles;

  word_t      key_pool [KEY_POOL];
  logic [1:0] cmd;
  word_t      k;
  word_t      v;
  int         pick;
  int         ins_pct;
  int         rem_pct;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  unordered_key_table_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  unordered_key_table_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .dup_seen    (dup_seen),
    .full_seen   (full_seen),
    .empty_seen  (empty_seen)
  );

  initial cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, outstanding);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic issue(input logic [1:0] c, input word_t key, input word_t val);
    @(negedge clk);
    start  <= 1'b1;
    in_req <= '{command: c, key: key, entry_value: val};
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  initial begin
    rst_n  = 1'b0;
    start  = 1'b0;
    in_req = '0;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = WORD_MIN;
    key_pool[1] = WORD_MAX;
    key_pool[2] = '0;
    key_pool[3] = -1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // empty table
    issue(CMD_SEARCH, '0, '0);
    issue(CMD_REMOVE, '0, '0);
    issue(CMD_UNUSED, -1, -1);
    // extreme keys and values
    issue(CMD_INSERT, WORD_MIN, WORD_MAX);
    issue(CMD_INSERT, WORD_MAX, WORD_MIN);
    issue(CMD_INSERT, '0, '0);
    issue(CMD_INSERT, -1, -1);
    issue(CMD_INSERT, WORD_MIN, 32'h1234_5678);
    issue(CMD_SEARCH, WORD_MAX, '0);
    issue(CMD_UNUSED, -1, '0);
    issue(CMD_SEARCH, 32'h0000_3039, '0);
    // remove from the middle, the front and the back
    issue(CMD_REMOVE, WORD_MAX, '0);
    issue(CMD_SEARCH, '0, '0);
    issue(CMD_REMOVE, 32'h0000_0007, '0);
    issue(CMD_REMOVE, WORD_MIN, '0);
    issue(CMD_REMOVE, -1, '0);
    issue(CMD_REMOVE, '0, '0);
    issue(CMD_REMOVE, -1, '0);
    issue(CMD_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
    issue(CMD_SEARCH, 32'h5555_5555, '0);

    // alternate fill-heavy and drain-heavy blocks
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ((n / BLOCK_LEN) % 2 == 0) begin
        ins_pct = 70;
        rem_pct = 12;
      end else begin
        ins_pct = 15;
        rem_pct = 60;
      end
      pick = $urandom_range(99);
      if (pick < 3) cmd = CMD_UNUSED;
      else if (pick < 3 + ins_pct) cmd = CMD_INSERT;
      else if (pick < 3 + ins_pct + rem_pct) cmd = CMD_REMOVE;
      else cmd = CMD_SEARCH;
      if ($urandom_range(9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(KEY_POOL - 1)];
      case ($urandom_range(15))
        0:       v = WORD_MIN;
        1:       v = WORD_MAX;
        default: v = $urandom;
      endcase
      if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(6) == 0)
        pause($urandom_range(14, 1));
      issue(cmd, k, v);
    end

    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("%0d results checked over directed and random requests", checked);
    $display("rejections seen: %0d duplicate, %0d table full, %0d table empty",
             dup_seen, full_seen, empty_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ unordered_key_table_unit.f @@
hw/rtl/ukt_pkg.sv
hw/rtl/ukt_cell.sv
hw/rtl/ukt_encode.sv
hw/rtl/unordered_key_table_unit.sv
hw/rtl/ukt_checker.sv
tb/unordered_key_table_checker.sv
tb/unordered_key_table_unit_test.sv
